// File: rtl/swvs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package swvs_pkg;

  // Field widths of one tick and of the configuration port.
  localparam int unsigned PRICE_BITS = 20;
  localparam int unsigned QTY_BITS   = 24;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned TENTHS_W   = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUY_TENTHS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SELL_TENTHS = 2'd2;

  // Threshold values after reset.
  localparam logic [TENTHS_W-1:0] BUY_TENTHS_RESET  = 4'd6;
  localparam logic [TENTHS_W-1:0] SELL_TENTHS_RESET = 4'd4;

  // Decision codes.
  localparam logic [1:0] DEC_HOLD = 2'd0;
  localparam logic [1:0] DEC_BUY  = 2'd1;
  localparam logic [1:0] DEC_SELL = 2'd2;

  // Shared multiplier: a 64-bit operand taken in two 32-bit halves against a 32-bit one.
  localparam int unsigned MUL_HALF_W = 32;
  localparam int unsigned MUL_A_W    = 64;
  localparam int unsigned MUL_P_W    = 64;
  localparam int unsigned MUL_R_W    = 96;

  // Sequencer steps. Product p is issued in steps 2p and 2p+1 and completes in step 2p+2.
  localparam int unsigned          STEP_W        = 5;
  localparam logic [STEP_W-1:0]    STEP_FIRST    = 5'd0;
  localparam logic [STEP_W-1:0]    STEP_NOTIONAL = 5'd4;
  localparam logic [STEP_W-1:0]    STEP_SQUARE   = 5'd8;
  localparam logic [STEP_W-1:0]    STEP_VWAP     = 5'd12;
  localparam logic [STEP_W-1:0]    STEP_BUY      = 5'd14;
  localparam logic [STEP_W-1:0]    STEP_SELL     = 5'd16;
  localparam logic [STEP_W-1:0]    STEP_LAST     = 5'd20;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } seq_state_e;

  // Products in the order the sequencer issues them.
  typedef enum logic [3:0] {
    PR_PX_SZ,
    PR_LPX_LSZ,
    PR_PX_PX,
    PR_LPX_LPX,
    PR_NOT_W,
    PR_PT_ST,
    PR_PAIR_BUY,
    PR_PAIR_SELL,
    PR_SQ_W,
    PR_PT_PT
  } prod_e;

  typedef struct packed {
    logic [PRICE_BITS-1:0] price;
    logic [QTY_BITS-1:0]   trade_size;
    logic [QTY_BITS-1:0]   bid_qty;
    logic [QTY_BITS-1:0]   ask_qty;
  } tick_t;

  typedef struct packed {
    logic [1:0]  decision;
    logic        degenerate;
    logic [27:0] window_price_sum;
    logic [51:0] window_notional;
    logic [31:0] window_qty;
    logic [31:0] window_bid;
    logic [31:0] window_ask;
    logic [55:0] variance_numerator;
  } signal_t;

endpackage

`default_nettype wire

// File: rtl/sliding_window_vwap_signal_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Sliding-window VWAP signal unit. Each request carries one market tick; the unit keeps the
// last window_len ticks in a ring memory and exact running sums of price, price squared,
// notional, size, bid and ask, and returns one result per tick: a buy, sell or hold decision,
// a degenerate flag, the window sums and the price variance numerator. All arithmetic runs
// through one 32 x 32 multiplier under a step sequencer: ten products, each in two halves.
// A new request is taken only once the sequence for the one before has ended; a result held
// by a stall keeps the sequence in its last step. The result sits in an output register, so
// the next request is accepted while it waits. Writing window_len empties the window at once;
// no clearing pass is needed, after reset or otherwise, because ring entries are only read
// back once the write pointer has gone round.
module sliding_window_vwap_signal_unit #(
  parameter int unsigned WINDOW_MAX = 256
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  swvs_pkg::tick_t                    in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output swvs_pkg::signal_t                  out_data_o,
  input  logic                               cfg_we_i,
  input  logic [swvs_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [swvs_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import swvs_pkg::*;

  localparam int unsigned LW     = $clog2(WINDOW_MAX);
  localparam int unsigned SLOT_W = LW;
  localparam int unsigned WL_W   = $clog2(WINDOW_MAX + 1);
  localparam int unsigned PT_W   = PRICE_BITS + LW;
  localparam int unsigned SQ_W   = 2 * PRICE_BITS + LW;
  localparam int unsigned NT_W   = PRICE_BITS + QTY_BITS + LW;
  localparam int unsigned QT_W   = QTY_BITS + LW;
  localparam int unsigned PAIR_W = QT_W + 1;

  seq_state_e                 state_q, state_d;
  logic [STEP_W-1:0]          step_q, step_d;
  logic                       adv;
  logic                       out_free;
  logic                       in_acc;
  logic                       issue;
  logic                       landing;
  logic                       cfg_wlen_wr;

  logic [WL_W-1:0]            wlen_q;
  logic [WL_W-1:0]            wlen_new;
  logic [TENTHS_W-1:0]        buy_q;
  logic [TENTHS_W-1:0]        sell_q;

  logic [SLOT_W-1:0]          slot_q;
  logic [WL_W-1:0]            slot_inc;
  logic                       wrapped_q;
  logic                       leave_ok_q;
  tick_t                      ring_mem [WINDOW_MAX];
  tick_t                      ring_rd_q;
  tick_t                      tick_q;
  tick_t                      lv_tick;

  logic [PT_W-1:0]            pt_q;
  logic [SQ_W-1:0]            sq_q;
  logic [NT_W-1:0]            nt_q;
  logic [QT_W-1:0]            qt_q;
  logic [QT_W-1:0]            bid_q;
  logic [QT_W-1:0]            ask_q;
  logic [PAIR_W-1:0]          pair;

  prod_e                      prod;
  logic [MUL_A_W-1:0]         a_sel;
  logic [MUL_HALF_W-1:0]      a_part;
  logic [MUL_HALF_W-1:0]      b_sel;
  logic [MUL_P_W-1:0]         mul_q;
  logic [MUL_P_W-1:0]         acc_q;
  logic [MUL_R_W-1:0]         res_q;
  logic [MUL_R_W-1:0]         result;
  logic [MUL_R_W-1:0]         bid10;

  logic                       vw_gt_q;
  logic                       vw_lt_q;
  logic                       bp_gt_q;
  logic                       sp_lt_q;
  logic                       degenerate;
  logic [1:0]                 decision;

  signal_t                    out_q;
  logic                       out_valid_q;

  // Handshake decode.
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Sequencer state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= STEP_FIRST;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Next state and step advance. The last step waits until the output register is free.
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    adv     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_RUN;
          step_d  = STEP_FIRST;
        end
      end
      ST_RUN: begin
        adv = (step_q != STEP_LAST) || out_free;
        if (adv) begin
          if (step_q == STEP_LAST) begin
            state_d = ST_IDLE;
            step_d  = STEP_FIRST;
          end else begin
            step_d = step_q + STEP_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
        step_d  = STEP_FIRST;
      end
    endcase
  end

  assign issue   = adv && (step_q < STEP_LAST);
  assign landing = (step_q != STEP_FIRST) && !step_q[0];

  // Window length saturates into the range one to the ring depth.
  always_comb begin
    if (cfg_data_i == '0) begin
      wlen_new = WL_W'(1);
    end else if (32'(cfg_data_i) > 32'(WINDOW_MAX)) begin
      wlen_new = WL_W'(WINDOW_MAX);
    end else begin
      wlen_new = WL_W'(cfg_data_i);
    end
  end

  assign cfg_wlen_wr = cfg_we_i && (cfg_idx_i == CFG_WINDOW_LEN);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= WL_W'(WINDOW_MAX);
      buy_q  <= BUY_TENTHS_RESET;
      sell_q <= SELL_TENTHS_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_WINDOW_LEN) begin
        wlen_q <= wlen_new;
      end
      if (cfg_idx_i == CFG_BUY_TENTHS) begin
        buy_q <= cfg_data_i[TENTHS_W-1:0];
      end
      if (cfg_idx_i == CFG_SELL_TENTHS) begin
        sell_q <= cfg_data_i[TENTHS_W-1:0];
      end
    end
  end

  // Ring memory: the leaving tick is read on acceptance, the new tick written in the first step.
  always_ff @(posedge clk_i) begin
    if (adv && (step_q == STEP_FIRST)) begin
      ring_mem[slot_q] <= tick_q;
    end
    if (in_acc) begin
      ring_rd_q <= ring_mem[slot_q];
    end
  end

  // The incoming tick is held for the whole sequence.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      tick_q <= in_data_i;
    end
  end

  // A slot only holds a real tick once the pointer has gone round since the window was emptied.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leave_ok_q <= 1'b0;
    end else if (in_acc) begin
      leave_ok_q <= wrapped_q;
    end
  end

  assign lv_tick  = leave_ok_q ? ring_rd_q : '0;
  assign slot_inc = WL_W'(slot_q) + WL_W'(1);
  assign pair     = PAIR_W'(bid_q) + PAIR_W'(ask_q);

  // Running sums and the write pointer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q    <= '0;
      wrapped_q <= 1'b0;
      pt_q      <= '0;
      sq_q      <= '0;
      nt_q      <= '0;
      qt_q      <= '0;
      bid_q     <= '0;
      ask_q     <= '0;
    end else if (cfg_wlen_wr) begin
      slot_q    <= '0;
      wrapped_q <= 1'b0;
      pt_q      <= '0;
      sq_q      <= '0;
      nt_q      <= '0;
      qt_q      <= '0;
      bid_q     <= '0;
      ask_q     <= '0;
    end else if (adv) begin
      if (step_q == STEP_FIRST) begin
        pt_q  <= pt_q + PT_W'(tick_q.price) - PT_W'(lv_tick.price);
        qt_q  <= qt_q + QT_W'(tick_q.trade_size) - QT_W'(lv_tick.trade_size);
        bid_q <= bid_q + QT_W'(tick_q.bid_qty) - QT_W'(lv_tick.bid_qty);
        ask_q <= ask_q + QT_W'(tick_q.ask_qty) - QT_W'(lv_tick.ask_qty);
        if (slot_inc >= wlen_q) begin
          slot_q    <= '0;
          wrapped_q <= 1'b1;
        end else begin
          slot_q <= SLOT_W'(slot_inc);
        end
      end
      // Entering notional is held in res_q; the leaving one completes now.
      if (step_q == STEP_NOTIONAL) begin
        nt_q <= nt_q + NT_W'(res_q) - NT_W'(result);
      end
      // Likewise for the squared prices.
      if (step_q == STEP_SQUARE) begin
        sq_q <= sq_q + SQ_W'(res_q) - SQ_W'(result);
      end
    end
  end

  // Operand selection for the shared multiplier.
  assign prod = prod_e'(step_q[STEP_W-1:1]);

  always_comb begin
    case (prod)
      PR_PX_SZ: begin
        a_sel = MUL_A_W'(tick_q.trade_size);
        b_sel = MUL_HALF_W'(tick_q.price);
      end
      PR_LPX_LSZ: begin
        a_sel = MUL_A_W'(lv_tick.trade_size);
        b_sel = MUL_HALF_W'(lv_tick.price);
      end
      PR_PX_PX: begin
        a_sel = MUL_A_W'(tick_q.price);
        b_sel = MUL_HALF_W'(tick_q.price);
      end
      PR_LPX_LPX: begin
        a_sel = MUL_A_W'(lv_tick.price);
        b_sel = MUL_HALF_W'(lv_tick.price);
      end
      PR_NOT_W: begin
        a_sel = MUL_A_W'(nt_q);
        b_sel = MUL_HALF_W'(wlen_q);
      end
      PR_PT_ST: begin
        a_sel = MUL_A_W'(qt_q);
        b_sel = MUL_HALF_W'(pt_q);
      end
      PR_PAIR_BUY: begin
        a_sel = MUL_A_W'(pair);
        b_sel = MUL_HALF_W'(buy_q);
      end
      PR_PAIR_SELL: begin
        a_sel = MUL_A_W'(pair);
        b_sel = MUL_HALF_W'(sell_q);
      end
      PR_SQ_W: begin
        a_sel = MUL_A_W'(sq_q);
        b_sel = MUL_HALF_W'(wlen_q);
      end
      PR_PT_PT: begin
        a_sel = MUL_A_W'(pt_q);
        b_sel = MUL_HALF_W'(pt_q);
      end
      default: begin
        a_sel = '0;
        b_sel = '0;
      end
    endcase
  end

  assign a_part = step_q[0] ? a_sel[MUL_A_W-1:MUL_HALF_W] : a_sel[MUL_HALF_W-1:0];

  // The high partial product joins the low one held in the accumulator.
  assign result = MUL_R_W'(acc_q) + {mul_q, {MUL_HALF_W{1'b0}}};

  // Shared multiplier, low half accumulator and last completed product.
  always_ff @(posedge clk_i) begin
    if (issue) begin
      mul_q <= MUL_P_W'(a_part) * MUL_P_W'(b_sel);
    end
    if (adv && step_q[0]) begin
      acc_q <= mul_q;
    end
    if (adv && landing) begin
      res_q <= result;
    end
  end

  assign bid10 = (MUL_R_W'(bid_q) << 3) + (MUL_R_W'(bid_q) << 1);

  // Cross-multiplied comparisons, taken as their second product completes.
  always_ff @(posedge clk_i) begin
    if (adv && (step_q == STEP_VWAP)) begin
      vw_gt_q <= res_q > result;
      vw_lt_q <= res_q < result;
    end
    if (adv && (step_q == STEP_BUY)) begin
      bp_gt_q <= bid10 > result;
    end
    if (adv && (step_q == STEP_SELL)) begin
      sp_lt_q <= bid10 < result;
    end
  end

  // Decision from the pressure and VWAP tests.
  always_comb begin
    degenerate = (qt_q == '0) || (pair == '0);
    decision   = DEC_HOLD;
    if (!degenerate) begin
      if (bp_gt_q && vw_gt_q) begin
        decision = DEC_BUY;
      end else if (sp_lt_q && vw_lt_q) begin
        decision = DEC_SELL;
      end
    end
  end

  // Output register; the variance numerator completes in the last step.
  always_ff @(posedge clk_i) begin
    if (adv && (step_q == STEP_LAST)) begin
      out_q.decision           <= decision;
      out_q.degenerate         <= degenerate;
      out_q.window_price_sum   <= 28'(pt_q);
      out_q.window_notional    <= 52'(nt_q);
      out_q.window_qty         <= 32'(qt_q);
      out_q.window_bid         <= 32'(bid_q);
      out_q.window_ask         <= 32'(ask_q);
      out_q.variance_numerator <= 56'(res_q - result);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && (step_q == STEP_LAST)) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // The step counter rests at zero whenever the sequencer is idle.
  a_idle_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (step_q == STEP_FIRST))
    else $error("step counter not at zero while idle");

  // An accepted request starts the sequence from its first step.
  a_accept_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_RUN) && (step_q == STEP_FIRST))
    else $error("accepted request did not start the sequence");

  // A result appears only out of the last step.
  a_out_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past((state_q == ST_RUN) && (step_q == STEP_LAST)))
    else $error("result raised outside the last step");

  // The write pointer stays inside the active window.
  a_slot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WL_W'(slot_q) < wlen_q)
    else $error("write pointer beyond window length");

  // The window length stays between one and the ring depth.
  a_wlen_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wlen_q != '0) && (wlen_q <= WL_W'(WINDOW_MAX)))
    else $error("window length out of range");

endmodule

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import swvs_pkg::*;

  localparam int unsigned WIN_MAX     = 256;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned PHASES      = 12;
  localparam int unsigned PHASE_TICKS = 50;
  localparam int unsigned DRAIN_WAIT  = 40;
  // Index 3 decodes to no register at all.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // One line of the directed script: either a register write or a tick request.
  typedef struct packed {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    tick_t                 tick;
    bit                    known;
    signal_t               want;
  } script_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  tick_t                 in_data;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  signal_t               out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  sliding_window_vwap_signal_unit #(
    .WINDOW_MAX(WIN_MAX)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Clock with a 20 ns period.
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Safety net in case the unit stops answering.
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Shadow copy of the window, the running sums and the registers.
  int unsigned  win_len;
  logic [3:0]   buy_th;
  logic [3:0]   sell_th;
  logic [19:0]  hist_price [WIN_MAX];
  logic [23:0]  hist_size  [WIN_MAX];
  logic [23:0]  hist_bid   [WIN_MAX];
  logic [23:0]  hist_ask   [WIN_MAX];
  int unsigned  slot_ptr;
  logic [63:0]  sum_px;
  logic [63:0]  sum_px2;
  logic [63:0]  sum_notional;
  logic [63:0]  sum_size;
  logic [63:0]  sum_bid;
  logic [63:0]  sum_ask;

  signal_t      pending_signals [$];
  script_row_t  script [$];
  signal_t      oldest_signal;
  int unsigned  mismatches   = 0;
  int unsigned  stall_budget = 0;
  int unsigned  taken_count  = 0;
  int unsigned  stall_seen   = 0;
  bit           quiet        = 1'b0;

  function automatic void clear_window();
    for (int i = 0; i < WIN_MAX; i++) begin
      hist_price[i] = '0;
      hist_size[i]  = '0;
      hist_bid[i]   = '0;
      hist_ask[i]   = '0;
    end
    slot_ptr     = 0;
    sum_px       = '0;
    sum_px2      = '0;
    sum_notional = '0;
    sum_size     = '0;
    sum_bid      = '0;
    sum_ask      = '0;
  endfunction

  // Register write as the unit sees it; a new window length saturates and empties the window.
  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_WINDOW_LEN: begin
        if (data == 0) win_len = 1;
        else if (data > WIN_MAX) win_len = WIN_MAX;
        else win_len = data;
        clear_window();
      end
      CFG_BUY_TENTHS:  buy_th  = data[TENTHS_W-1:0];
      CFG_SELL_TENTHS: sell_th = data[TENTHS_W-1:0];
      default: ;
    endcase
  endfunction

  // Push one tick into the window, retire the oldest, and work out the signal.
  function automatic signal_t slide_window(tick_t t);
    signal_t      r;
    int unsigned  s;
    logic [63:0]  px, sz, lpx, lsz, pair, var_num;
    logic [127:0] vw_left, vw_right, bid_scaled, buy_rhs, sell_rhs;
    s = slot_ptr;
    if (s >= win_len) s = 0;
    px  = 64'(t.price);
    sz  = 64'(t.trade_size);
    lpx = 64'(hist_price[s]);
    lsz = 64'(hist_size[s]);
    sum_px       = sum_px + px - lpx;
    sum_px2      = sum_px2 + px * px - lpx * lpx;
    sum_notional = sum_notional + px * sz - lpx * lsz;
    sum_size     = sum_size + sz - lsz;
    sum_bid      = sum_bid + 64'(t.bid_qty) - 64'(hist_bid[s]);
    sum_ask      = sum_ask + 64'(t.ask_qty) - 64'(hist_ask[s]);
    hist_price[s] = t.price;
    hist_size[s]  = t.trade_size;
    hist_bid[s]   = t.bid_qty;
    hist_ask[s]   = t.ask_qty;
    s++;
    if (s >= win_len) s = 0;
    slot_ptr = s;

    r = '0;
    r.decision = DEC_HOLD;
    pair = sum_bid + sum_ask;
    if (sum_size == 0 || pair == 0) begin
      r.degenerate = 1'b1;
    end else begin
      // Compare VWAP with the mean price and the bid share with the thresholds, all
      // cross-multiplied so that nothing is divided.
      vw_left    = 128'(sum_notional) * 128'(win_len);
      vw_right   = 128'(sum_px) * 128'(sum_size);
      bid_scaled = 128'(sum_bid) * 128'd10;
      buy_rhs    = 128'(buy_th) * 128'(pair);
      sell_rhs   = 128'(sell_th) * 128'(pair);
      if (bid_scaled > buy_rhs && vw_left > vw_right) r.decision = DEC_BUY;
      else if (bid_scaled < sell_rhs && vw_left < vw_right) r.decision = DEC_SELL;
    end
    var_num = 64'(win_len) * sum_px2 - sum_px * sum_px;

    r.window_price_sum   = sum_px[27:0];
    r.window_notional    = sum_notional[51:0];
    r.window_qty         = sum_size[31:0];
    r.window_bid         = sum_bid[31:0];
    r.window_ask         = sum_ask[31:0];
    r.variance_numerator = var_num[55:0];
    return r;
  endfunction

  // Quantity draw that favours zero, full scale and small values now and then.
  function automatic logic [23:0] rand_qty();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 24'($urandom_range(0, 255));
      default: return 24'($urandom());
    endcase
  endfunction

  // Random tick; the regime leaves the book as drawn or tilts it towards bids, towards asks, or towards tiny values.
  function automatic tick_t random_tick(int unsigned regime);
    tick_t t;
    case ($urandom_range(0, 9))
      0:       t.price = '0;
      1:       t.price = '1;
      default: t.price = 20'($urandom());
    endcase
    t.trade_size = rand_qty();
    t.bid_qty    = rand_qty();
    t.ask_qty    = rand_qty();
    case (regime)
      1: t.ask_qty = t.ask_qty >> $urandom_range(1, 12);
      2: t.bid_qty = t.bid_qty >> $urandom_range(1, 12);
      3: begin
        t.price      = 20'($urandom_range(0, 15));
        t.trade_size = 24'($urandom_range(0, 3));
        t.bid_qty    = 24'($urandom_range(0, 3));
        t.ask_qty    = 24'($urandom_range(0, 3));
      end
      default: ;
    endcase
    return t;
  endfunction

  task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    script_row_t r;
    r        = '0;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    script.push_back(r);
  endtask

  task automatic add_tick(logic [19:0] p, logic [23:0] s, logic [23:0] b, logic [23:0] a);
    script_row_t r;
    r      = '0;
    r.tick = {p, s, b, a};
    script.push_back(r);
  endtask

  task automatic add_known(logic [19:0] p, logic [23:0] s, logic [23:0] b, logic [23:0] a,
                           signal_t want);
    script_row_t r;
    r       = '0;
    r.tick  = {p, s, b, a};
    r.known = 1'b1;
    r.want  = want;
    script.push_back(r);
  endtask

  // Register writes wait until every outstanding result has been collected.
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    in_valid = 1'b0;
    while (pending_signals.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    apply_register(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Offer one tick request after a random gap and record what it should produce.
  task automatic send_tick(tick_t t, bit known, signal_t want);
    int unsigned gap;
    signal_t     predicted;
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  = t;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    predicted = slide_window(t);
    pending_signals.push_back(known ? want : predicted);
    @(negedge clk);
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("mismatch in %s: expected %0h, got %0h", name, want, got);
    end
  endtask

  // Result side: compare every collected result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_signals.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result %h with nothing outstanding", out_data);
      end else begin
        oldest_signal = pending_signals.pop_front();
        check_field("decision", 64'(oldest_signal.decision), 64'(out_data.decision));
        check_field("degenerate", 64'(oldest_signal.degenerate), 64'(out_data.degenerate));
        check_field("window_price_sum", 64'(oldest_signal.window_price_sum),
                    64'(out_data.window_price_sum));
        check_field("window_notional", 64'(oldest_signal.window_notional),
                    64'(out_data.window_notional));
        check_field("window_qty", 64'(oldest_signal.window_qty), 64'(out_data.window_qty));
        check_field("window_bid", 64'(oldest_signal.window_bid), 64'(out_data.window_bid));
        check_field("window_ask", 64'(oldest_signal.window_ask), 64'(out_data.window_ask));
        check_field("variance_numerator", 64'(oldest_signal.variance_numerator),
                    64'(out_data.variance_numerator));
      end
      taken_count++;
    end
  end

  // A stall budget is drawn after each collected result and holds the next result back while
  // it lasts; the budget counts down only while a result is waiting.
  always @(negedge clk) begin
    if (taken_count != stall_seen) begin
      stall_seen   = taken_count;
      stall_budget = quiet ? 0 : $urandom_range(0, 7);
    end
    out_stall <= (stall_budget != 0);
    if (out_valid && stall_budget != 0) stall_budget--;
  end

  initial begin : stimulus
    int unsigned regime;
    tick_t       t;

    in_valid = 1'b0;
    in_data  = '0;
    cfg_we   = 1'b0;
    cfg_idx  = '0;
    cfg_data = '0;
    rst_n    = 1'b0;
    win_len  = WIN_MAX;
    buy_th   = BUY_TENTHS_RESET;
    sell_th  = SELL_TENTHS_RESET;
    clear_window();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed script: reset state, full-scale and empty ticks, both decisions, threshold
    // extremes, window lengths that saturate, and a write to the unused index.
    add_known(20'd0, 24'd0, 24'd0, 24'd0,
              {DEC_HOLD, 1'b1, 28'd0, 52'd0, 32'd0, 32'd0, 32'd0, 56'd0});
    add_cfg(CFG_WINDOW_LEN, 9'd1);
    add_known(20'hFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'd0,
              {DEC_HOLD, 1'b0, 28'hFFFFF, 52'hFFFFEF00001, 32'hFFFFFF, 32'hFFFFFF, 32'd0,
               56'd0});
    add_known(20'hFFFFF, 24'd0, 24'd0, 24'd0,
              {DEC_HOLD, 1'b1, 28'hFFFFF, 52'd0, 32'd0, 32'd0, 32'd0, 56'd0});
    add_known(20'd0, 24'hFFFFFF, 24'd0, 24'hFFFFFF,
              {DEC_HOLD, 1'b0, 28'd0, 52'd0, 32'hFFFFFF, 32'd0, 32'hFFFFFF, 56'd0});
    add_cfg(CFG_WINDOW_LEN, 9'd2);
    add_tick(20'd10, 24'd1, 24'd9, 24'd1);
    add_tick(20'd20, 24'd9, 24'd9, 24'd1);
    add_tick(20'd20, 24'd1, 24'd1, 24'd9);
    add_tick(20'd10, 24'd9, 24'd1, 24'd9);
    add_cfg(CFG_BUY_TENTHS, 9'd0);
    add_cfg(CFG_SELL_TENTHS, 9'd10);
    add_tick(20'd30, 24'd5, 24'd0, 24'd7);
    add_tick(20'd5, 24'd5, 24'd7, 24'd0);
    add_cfg(CFG_BUY_TENTHS, 9'd15);
    add_cfg(CFG_SELL_TENTHS, 9'd15);
    add_tick(20'd40, 24'd3, 24'd7, 24'd7);
    add_tick(20'd8, 24'd1, 24'd7, 24'd7);
    add_cfg(CFG_WINDOW_LEN, 9'd0);
    add_tick(20'hFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    add_tick(20'd3, 24'd2, 24'd1, 24'd0);
    add_cfg(CFG_WINDOW_LEN, 9'h1FF);
    add_tick(20'hFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    add_tick(20'd1, 24'd2, 24'd3, 24'd4);
    add_cfg(CFG_UNUSED, 9'h1FF);
    add_tick(20'hFFFFF, 24'd1, 24'hFFFFFF, 24'd1);
    add_cfg(CFG_BUY_TENTHS, 9'd6);
    add_cfg(CFG_SELL_TENTHS, 9'd4);

    foreach (script[i]) begin
      if (script[i].is_cfg) write_register(script[i].idx, script[i].data);
      else send_tick(script[i].tick, script[i].known, script[i].want);
    end

    // Random phases, each with its own window, thresholds, book tilt and idling mood.
    for (int phase = 0; phase < PHASES; phase++) begin
      case ($urandom_range(0, 5))
        0:       write_register(CFG_WINDOW_LEN, 9'd1);
        1:       write_register(CFG_WINDOW_LEN, 9'($urandom_range(2, 8)));
        2:       write_register(CFG_WINDOW_LEN, 9'($urandom_range(9, 64)));
        3:       write_register(CFG_WINDOW_LEN, 9'd256);
        4:       write_register(CFG_WINDOW_LEN, 9'($urandom_range(0, 511)));
        default: write_register(CFG_WINDOW_LEN, 9'd255);
      endcase
      write_register(CFG_BUY_TENTHS, ($urandom_range(0, 5) == 0) ?
                     9'($urandom_range(11, 15)) : 9'($urandom_range(0, 10)));
      write_register(CFG_SELL_TENTHS, ($urandom_range(0, 5) == 0) ?
                     9'($urandom_range(11, 15)) : 9'($urandom_range(0, 10)));
      if (phase % 4 == 3) write_register(CFG_UNUSED, 9'($urandom_range(0, 511)));
      quiet  = ($urandom_range(0, 3) == 0);
      regime = $urandom_range(0, 3);
      for (int k = 0; k < PHASE_TICKS; k++) begin
        t = random_tick(regime);
        send_tick(t, 1'b0, '0);
      end
    end

    // Drain the outstanding results, then allow a little extra time for strays.
    in_valid = 1'b0;
    while (pending_signals.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && pending_signals.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
